>>> rtl/grc_pkg.sv
// Package: shared types, constants and the sine magnitude function for the column ray caster.
package grc_pkg;

    localparam int MAP_SIDE_DEF        = 16;
    localparam int MAX_STEPS_DEF       = 625;
    localparam int SINE_TABLE_SIZE_DEF = 1024;

    localparam int          HALF_FOV     = 5461;
    localparam int          HEIGHT_CAP   = 400;
    localparam int          HEIGHT_SCALE = 512000;
    localparam int          STEP_DIV     = 125;
    localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

    localparam int DIV_NW = 30;
    localparam int DIV_DW = 28;

    localparam logic [2:0] CFG_PLAYER_X     = 3'd0;
    localparam logic [2:0] CFG_PLAYER_Y     = 3'd1;
    localparam logic [2:0] CFG_VIEW_ANGLE   = 3'd2;
    localparam logic [2:0] CFG_VIEW_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_VIEW_COLUMNS = 3'd4;
    localparam logic [2:0] CFG_TEXTURE_SIZE = 3'd5;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] cell_index;
        logic [3:0] cell_code;
        logic [9:0] column;
    } grc_in_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] wall_texture;
        logic [8:0] wall_height;
        logic [7:0] texture_x;
    } grc_out_t;

    // Magnitude of sine in Q14 for a first-quadrant phase r (0..16384), degree 9 series.
    function automatic logic [14:0] sine_mag(input logic [16:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] v;
        x  = ({47'd0, r} * HALF_PI_Q30) >> 14;
        x2 = (x * x) >> 30;
        a  = Q30_ONE - x2 / 72;
        a  = Q30_ONE - ((x2 * a) >> 30) / 42;
        a  = Q30_ONE - ((x2 * a) >> 30) / 20;
        a  = Q30_ONE - ((x2 * a) >> 30) / 6;
        s  = (x * a) >> 30;
        v  = (s + 64'd32768) >> 16;
        if (v > 64'd16384)
        begin
            v = 64'd16384;
        end
        return v[14:0];
    endfunction

endpackage

>>> rtl/grid_ray_caster_column.sv
// Top level: column ray caster over a square cell map.
// Sequence: a map write is taken without leaving the idle state; a cast first divides
// for the ray angle, does three sine ROM reads and a prep step, then marches (one map
// read per step, up to MAX_STEPS steps), then divides for the height and loads the item.
// Throughput: one item at a time; a cast holds the input until its result is loaded,
// including any wait for the output register. Reset: map cells read empty,
// configuration registers take their defaults, no result pending.
module grid_ray_caster_column #(
    parameter int MAP_SIDE        = grc_pkg::MAP_SIDE_DEF,
    parameter int MAX_STEPS       = grc_pkg::MAX_STEPS_DEF,
    parameter int SINE_TABLE_SIZE = grc_pkg::SINE_TABLE_SIZE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  grc_pkg::grc_in_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output grc_pkg::grc_out_t out_item,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import grc_pkg::*;

    localparam int AW = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int KW = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDIV  = 4'd1;
    localparam logic [3:0] S_SN    = 4'd2;
    localparam logic [3:0] S_CS    = 4'd3;
    localparam logic [3:0] S_CR    = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_MARCH = 4'd6;
    localparam logic [3:0] S_HIT   = 4'd7;
    localparam logic [3:0] S_HDIV  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // configuration
    logic [15:0] px_reg, py_reg, va_reg;
    logic [10:0] vh_reg, vc_reg;
    logic [8:0]  ts_reg;

    logic [3:0]  state_reg, state_next;

    // cast setup
    logic [15:0]        rel_reg, rel_next;
    logic signed [15:0] sn_reg, sn_next, cs_reg, cs_next, cr_reg, cr_next;

    // per-step increments: step displacement = q + r/125 in Q12
    logic signed [8:0] qcx_reg, qcx_next, qcy_reg, qcy_next;
    logic [6:0]        rcx_reg, rcx_next, rcy_reg, rcy_next;

    // march accumulators
    logic [KW-1:0]      k_reg, k_next;
    logic signed [21:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [6:0]         rx_reg, rx_next, ry_reg, ry_next;

    // step whose map read is in flight
    logic               pv_reg, pv_next;
    logic [KW-1:0]      pk_reg, pk_next;
    logic [21:0]        pcx_reg, pcx_next, pcy_reg, pcy_next;

    // result fields
    logic        rh_reg, rh_next;
    logic [3:0]  rt_reg, rt_next;
    logic [8:0]  rc_reg, rc_next;
    logic [7:0]  rtx_reg, rtx_next;
    logic [KW-1:0] hk_reg, hk_next;

    logic     ov_reg, ov_next;
    grc_out_t oi_reg, oi_next;

    // shared divider
    logic              dv_start;
    logic [DIV_NW-1:0] dv_num;
    logic [DIV_DW-1:0] dv_den;
    logic              dv_done;
    logic [DIV_NW-1:0] dv_quo;

    // sine ROM
    logic [15:0]        rom_angle;
    logic signed [15:0] rom_val;

    // map
    logic          map_we;
    logic [AW-1:0] map_waddr, map_raddr;
    logic [3:0]    map_rdata;

    logic [10:0] cols;
    logic        in_acc;

    // step decomposition helpers
    logic [14:0] mcx, mcy;
    logic [28:0] pmx, pmy;
    logic [7:0]  q0x, q0y;
    logic [6:0]  r0x, r0y;

    // current step position
    logic signed [22:0] cx, cy;
    logic [9:0]         gx, gy;
    logic               cur_out;
    logic [7:0]         rx_sum, ry_sum;

    // texture coordinate of the hit step
    logic signed [11:0] fx, fy, fsel;
    logic [11:0]        ax, ay, asel;
    logic [8:0]         tsz;
    logic [20:0]        tprod;
    logic [8:0]         tmag;
    logic [8:0]         tex;

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    grc_sine #(
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_sine (
        .clk   (clk),
        .angle (rom_angle),
        .value (rom_val)
    );

    grc_map #(
        .MAP_SIDE (MAP_SIDE)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (in_item.cell_code),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign cols     = (vc_reg == 11'd0) ? 11'd1 : vc_reg;

    // map writes: drop indexes beyond the map
    assign map_we    = in_acc && (in_item.func == FUNC_WRITE)
                       && ({24'd0, in_item.cell_index} < 32'(MAP_SIDE * MAP_SIDE));
    assign map_waddr = AW'(in_item.cell_index);

    // floor(v/125) for |v| <= 16384 by reciprocal multiply (exact in this range)
    assign mcx = cs_reg[15] ? 15'(-cs_reg) : cs_reg[14:0];
    assign mcy = sn_reg[15] ? 15'(-sn_reg) : sn_reg[14:0];
    assign pmx = {14'd0, mcx} * 29'd8389;
    assign pmy = {14'd0, mcy} * 29'd8389;
    assign q0x = pmx[27:20];
    assign q0y = pmy[27:20];
    assign r0x = 7'(mcx - 15'(q0x * 8'd125));
    assign r0y = 7'(mcy - 15'(q0y * 8'd125));

    // position of the current step
    assign cx      = $signed({7'd0, px_reg}) + 23'(qx_reg);
    assign cy      = $signed({7'd0, py_reg}) + 23'(qy_reg);
    assign gx      = cx[21:12];
    assign gy      = cy[21:12];
    assign cur_out = (k_reg == KW'(MAX_STEPS)) || cx[22] || cy[22]
                     || ({22'd0, gx} >= 32'(MAP_SIDE)) || ({22'd0, gy} >= 32'(MAP_SIDE));
    assign rx_sum  = {1'b0, rx_reg} + {1'b0, rcx_reg};
    assign ry_sum  = {1'b0, ry_reg} + {1'b0, rcy_reg};
    assign map_raddr = AW'(32'(gy) * 32'(MAP_SIDE) + 32'(gx));

    // signed distance to the nearest cell edge; take the larger one
    assign fx   = $signed(pcx_reg[11:0]);
    assign fy   = $signed(pcy_reg[11:0]);
    assign ax   = fx[11] ? 12'(-fx) : fx;
    assign ay   = fy[11] ? 12'(-fy) : fy;
    assign fsel = (ay > ax) ? fy : fx;
    assign asel = (ay > ax) ? ay : ax;
    assign tsz  = (ts_reg > 9'd256) ? 9'd256 : ts_reg;
    assign tprod = {9'd0, asel} * {12'd0, tsz};
    assign tmag  = tprod[20:12];
    assign tex   = (fsel[11] && (tmag != 9'd0)) ? (tsz - tmag) : tmag;

    always_comb
    begin
        rom_angle = 16'(va_reg + rel_reg);
        case (state_reg)
            S_CS:    rom_angle = 16'(va_reg + rel_reg + 16'd16384);
            S_CR:    rom_angle = 16'(rel_reg + 16'd16384);
            default: rom_angle = 16'(va_reg + rel_reg);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        rel_next = rel_reg;
        sn_next = sn_reg;
        cs_next = cs_reg;
        cr_next = cr_reg;
        qcx_next = qcx_reg;
        qcy_next = qcy_reg;
        rcx_next = rcx_reg;
        rcy_next = rcy_reg;
        k_next = k_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        pv_next = pv_reg;
        pk_next = pk_reg;
        pcx_next = pcx_reg;
        pcy_next = pcy_reg;
        rh_next = rh_reg;
        rt_next = rt_reg;
        rc_next = rc_reg;
        rtx_next = rtx_reg;
        hk_next = hk_reg;
        dv_start = 1'b0;
        dv_num = DIV_NW'({in_item.column, 16'd0});
        dv_den = DIV_DW'(14'(cols * 11'd6));
        ov_next = ov_reg && out_stall;
        oi_next = oi_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (in_item.func == FUNC_CAST))
                begin
                    dv_start   = 1'b1;
                    state_next = S_RDIV;
                end
            end
            S_RDIV:
            begin
                if (dv_done)
                begin
                    rel_next   = 16'(dv_quo[15:0] - 16'(HALF_FOV));
                    state_next = S_SN;
                end
            end
            S_SN:
            begin
                state_next = S_CS;
            end
            S_CS:
            begin
                sn_next    = rom_val;
                state_next = S_CR;
            end
            S_CR:
            begin
                cs_next    = rom_val;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cr_next = rom_val;
                // signed floor split of the per-step displacement
                if (cs_reg[15] && (r0x != 7'd0))
                begin
                    qcx_next = -$signed({1'b0, q0x} + 9'd1);
                    rcx_next = 7'(STEP_DIV) - r0x;
                end
                else
                begin
                    qcx_next = cs_reg[15] ? -$signed({1'b0, q0x}) : $signed({1'b0, q0x});
                    rcx_next = r0x;
                end
                if (sn_reg[15] && (r0y != 7'd0))
                begin
                    qcy_next = -$signed({1'b0, q0y} + 9'd1);
                    rcy_next = 7'(STEP_DIV) - r0y;
                end
                else
                begin
                    qcy_next = sn_reg[15] ? -$signed({1'b0, q0y}) : $signed({1'b0, q0y});
                    rcy_next = r0y;
                end
                k_next     = '0;
                qx_next    = '0;
                qy_next    = '0;
                rx_next    = '0;
                ry_next    = '0;
                pv_next    = 1'b0;
                state_next = S_MARCH;
            end
            S_MARCH:
            begin
                if (pv_reg && (map_rdata != 4'd0))
                begin
                    // earlier step landed on a wall
                    rh_next    = 1'b1;
                    rt_next    = map_rdata - 4'd1;
                    rtx_next   = tex[7:0];
                    hk_next    = pk_reg;
                    state_next = S_HIT;
                end
                else if (cur_out)
                begin
                    rh_next    = 1'b0;
                    rt_next    = '0;
                    rc_next    = '0;
                    rtx_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    pv_next  = 1'b1;
                    pk_next  = k_reg;
                    pcx_next = cx[21:0];
                    pcy_next = cy[21:0];
                    k_next   = k_reg + 1'b1;
                    if (rx_sum >= 8'(STEP_DIV))
                    begin
                        rx_next = 7'(rx_sum - 8'(STEP_DIV));
                        qx_next = qx_reg + 22'(qcx_reg) + 22'sd1;
                    end
                    else
                    begin
                        rx_next = rx_sum[6:0];
                        qx_next = qx_reg + 22'(qcx_reg);
                    end
                    if (ry_sum >= 8'(STEP_DIV))
                    begin
                        ry_next = 7'(ry_sum - 8'(STEP_DIV));
                        qy_next = qy_reg + 22'(qcy_reg) + 22'sd1;
                    end
                    else
                    begin
                        ry_next = ry_sum[6:0];
                        qy_next = qy_reg + 22'(qcy_reg);
                    end
                end
            end
            S_HIT:
            begin
                if ((hk_reg == '0) || (cr_reg <= 16'sd0))
                begin
                    rc_next    = 9'(HEIGHT_CAP);
                    state_next = S_DONE;
                end
                else
                begin
                    dv_start   = 1'b1;
                    dv_num     = DIV_NW'(vh_reg * 19'(HEIGHT_SCALE));
                    dv_den     = DIV_DW'(hk_reg * cr_reg[14:0]);
                    state_next = S_HDIV;
                end
            end
            S_HDIV:
            begin
                if (dv_done)
                begin
                    rc_next    = (dv_quo > DIV_NW'(HEIGHT_CAP)) ? 9'(HEIGHT_CAP) : dv_quo[8:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    oi_next.hit = rh_reg;
                    oi_next.wall_texture = rt_reg;
                    oi_next.wall_height = rc_reg;
                    oi_next.texture_x = rtx_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            pv_reg    <= 1'b0;
            px_reg    <= 16'd12288;
            py_reg    <= 16'd12288;
            va_reg    <= 16'd26307;
            vh_reg    <= 11'd512;
            vc_reg    <= 11'd512;
            ts_reg    <= 9'd64;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            pv_reg    <= pv_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PLAYER_X:     px_reg <= cfg_data;
                    CFG_PLAYER_Y:     py_reg <= cfg_data;
                    CFG_VIEW_ANGLE:   va_reg <= cfg_data;
                    CFG_VIEW_HEIGHT:  vh_reg <= cfg_data[10:0];
                    CFG_VIEW_COLUMNS: vc_reg <= cfg_data[10:0];
                    CFG_TEXTURE_SIZE: ts_reg <= cfg_data[8:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg <= rel_next;
        sn_reg  <= sn_next;
        cs_reg  <= cs_next;
        cr_reg  <= cr_next;
        qcx_reg <= qcx_next;
        qcy_reg <= qcy_next;
        rcx_reg <= rcx_next;
        rcy_reg <= rcy_next;
        k_reg   <= k_next;
        qx_reg  <= qx_next;
        qy_reg  <= qy_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        pk_reg  <= pk_next;
        pcx_reg <= pcx_next;
        pcy_reg <= pcy_next;
        rh_reg  <= rh_next;
        rt_reg  <= rt_next;
        rc_reg  <= rc_next;
        rtx_reg <= rtx_next;
        hk_reg  <= hk_next;
        oi_reg  <= oi_next;
    end

    assign out_valid = ov_reg;
    assign out_item  = oi_reg;

`ifndef NO_ASSERTIONS
    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.hit) |-> (out_item.wall_texture == 4'd0
            && out_item.wall_height == 9'd0 && out_item.texture_x == 8'd0))
        else $error("miss result with nonzero fields");

    // height never exceeds the cap
    a_height_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.wall_height <= 9'(HEIGHT_CAP)))
        else $error("column height above cap");

    // step counter stays within the march length
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARCH) |-> (k_reg <= KW'(MAX_STEPS)))
        else $error("march step counter overran");
`endif

endmodule

>>> rtl/grc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module grc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [grc_pkg::DIV_NW-1:0] num,
    input  logic [grc_pkg::DIV_DW-1:0] den,
    output logic                      done,
    output logic [grc_pkg::DIV_NW-1:0] quo
);
    import grc_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] numq_reg, numq_next;
    logic [DIV_DW:0]   rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   trial;

    always_comb
    begin
        numq_next = numq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DIV_DW-1:0], numq_reg[DIV_NW-1]};
        if (start)
        begin
            numq_next = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = CW'(DIV_NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one numerator bit in, subtract when it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                numq_next = {numq_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                numq_next = {numq_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        numq_reg <= numq_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quo  = numq_reg;

endmodule

>>> rtl/grc_sine.sv
// Quarter-wave sine ROM with registered read, signed Q14 output.
module grc_sine #(
    parameter int SINE_TABLE_SIZE = grc_pkg::SINE_TABLE_SIZE_DEF
) (
    input  logic               clk,
    input  logic [15:0]        angle,
    output logic signed [15:0] value
);
    import grc_pkg::*;

    localparam int LN  = $clog2(SINE_TABLE_SIZE);
    localparam int QTR = SINE_TABLE_SIZE / 4;
    localparam int PH  = 65536 / SINE_TABLE_SIZE;

    typedef logic [14:0] qtab_t [0:QTR];

    function automatic qtab_t build_tab();
        qtab_t t;
        for (int i = 0; i <= QTR; i++)
        begin
            t[i] = sine_mag(17'(i * PH));
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_tab();

    logic [LN-1:0] idx;
    logic [LN-3:0] low;
    logic [LN-2:0] m;
    logic [14:0]   mag_reg;
    logic          neg_reg;

    assign idx = angle[15 -: LN];
    assign low = idx[LN-3:0];
    // mirror the odd quadrants
    assign m   = idx[LN-2] ? ((LN-1)'(QTR) - {1'b0, low}) : {1'b0, low};

    always_ff @(posedge clk)
    begin
        mag_reg <= QTAB[m];
        neg_reg <= idx[LN-1];
    end

    assign value = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

>>> rtl/grc_map.sv
// Cell map memory with per-entry valid bits; empty reads as zero.
module grc_map #(
    parameter int MAP_SIDE = grc_pkg::MAP_SIDE_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 we,
    input  logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0] waddr,
    input  logic [3:0]                           wdata,
    input  logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0] raddr,
    output logic [3:0]                           rdata
);
    localparam int DEPTH = MAP_SIDE * MAP_SIDE;

    logic [3:0]       mem [0:DEPTH-1];
    logic [DEPTH-1:0] vld_reg;
    logic [3:0]       q_reg;
    logic             qv_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            qv_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            qv_reg <= vld_reg[raddr];
        end
    end

    assign rdata = qv_reg ? q_reg : 4'd0;

endmodule
